[rtl/ogdi_pkg.sv]
// ogdi_pkg: shared types and constants of the occupancy grid disk inflation unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ogdi_pkg;

	typedef logic signed [7:0] occ_value_t;

	localparam int CFG_DW = 16;

	typedef enum logic [2:0] {
		CFG_WIDTH   = 3'd0,
		CFG_HEIGHT  = 3'd1,
		CFG_RADIUS  = 3'd2,
		CFG_THRESH  = 3'd3,
		CFG_UNKNOWN = 3'd4
	} cfg_idx_t;

	localparam logic REQ_CELL  = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	localparam occ_value_t THRESH_RESET = 8'sd50;

endpackage

`default_nettype wire

[rtl/ogdi_if.sv]
// ogdi_if: valid/ready channels for grid cells in and inflated cells out
// depends on ogdi_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ogdi_cell_if;
	logic                 valid;
	logic                 ready;
	logic                 req_type;
	ogdi_pkg::occ_value_t in_value;

	modport source (output valid, req_type, in_value, input ready);
	modport sink (input valid, req_type, in_value, output ready);
endinterface

interface ogdi_res_if;
	logic                 valid;
	logic                 ready;
	ogdi_pkg::occ_value_t out_value;
	logic                 last_cell;

	modport source (output valid, out_value, last_cell, input ready);
	modport sink (input valid, out_value, last_cell, output ready);
endinterface

`default_nettype wire

[rtl/occupancy_grid_disk_inflation_unit.sv]
// occupancy_grid_disk_inflation_unit: streaming disk inflation of an occupancy grid
// depends on ogdi_pkg, ogdi_if, ogdi_ram, ogdi_cell
// one beat per cycle in, one per cycle out while result is not stalled; a result passes
// stage 1, stage 2 and the output register after its window completes (radius rows plus
// radius cells later in raster order); one history ram read-modify-write per cycle sets the rate
// asynchronous reset clears counters and registers; ram contents are never cleared
`timescale 1ns / 1ps
`default_nettype none

module occupancy_grid_disk_inflation_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [2:0]                  cfg_index,
	input  wire logic [ogdi_pkg::CFG_DW-1:0] cfg_data,
	ogdi_cell_if.sink                        cell_in,
	ogdi_res_if.source                       result
);

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int WW     = $clog2(MAX_WIDTH+1);
	localparam int RW     = $clog2(MAX_RADIUS+1);
	localparam int TW     = WW + 16;
	localparam int NC     = 2*MAX_RADIUS + 1;
	localparam int HW     = 2*MAX_RADIUS;
	localparam int VA     = $clog2(MAX_RADIUS*MAX_WIDTH + MAX_RADIUS + 1);
	localparam int VDEPTH = 2**VA;

	// configuration
	logic [WW-1:0]        eff_w_q;
	logic [15:0]          eff_h_q;
	logic [RW-1:0]        eff_r_q;
	ogdi_pkg::occ_value_t thr_q;
	logic                 unk_q;
	logic [TW-1:0]        total_q;
	logic [TW-1:0]        lag_q;
	logic                 cfg_rst;

	assign cfg_rst = cfg_we && (cfg_index <= ogdi_pkg::CFG_UNKNOWN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= WW'(1);
			eff_h_q <= 16'd1;
			eff_r_q <= '0;
			thr_q   <= ogdi_pkg::THRESH_RESET;
			unk_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ogdi_pkg::CFG_WIDTH: begin
					if (cfg_data[10:0] == 11'd0) begin
						eff_w_q <= WW'(1);
					end else if (32'(cfg_data[10:0]) > MAX_WIDTH) begin
						eff_w_q <= WW'(MAX_WIDTH);
					end else begin
						eff_w_q <= WW'(cfg_data[10:0]);
					end
				end
				ogdi_pkg::CFG_HEIGHT: begin
					eff_h_q <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
				end
				ogdi_pkg::CFG_RADIUS: begin
					if (32'(cfg_data[3:0]) > MAX_RADIUS) begin
						eff_r_q <= RW'(MAX_RADIUS);
					end else begin
						eff_r_q <= RW'(cfg_data[3:0]);
					end
				end
				ogdi_pkg::CFG_THRESH: begin
					thr_q <= cfg_data[7:0];
				end
				ogdi_pkg::CFG_UNKNOWN: begin
					unk_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TW'(1);
			lag_q   <= '0;
		end else begin
			total_q <= TW'(eff_w_q) * TW'(eff_h_q);
			lag_q   <= TW'(eff_r_q) * TW'(eff_w_q) + TW'(eff_r_q);
		end
	end

	// disk masks per chain position
	logic [NC-1:0] disk_d [NC];
	logic [NC-1:0] disk_q [NC];

	always_comb begin
		int r;
		int dx;
		int dy;
		r = int'(eff_r_q);
		for (int k = 0; k < NC; k++) begin
			for (int j = 0; j < NC; j++) begin
				dx = r - k;
				dy = r - j;
				disk_d[k][j] = (r != 0) && (dx*dx + dy*dy <= r*r);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NC; k++) begin
				disk_q[k] <= '0;
			end
		end else begin
			disk_q <= disk_d;
		end
	end

	// stream bookkeeping of accepted beats
	logic          en;
	logic          acc;
	logic          is_drain;
	logic [TW-1:0] in_cnt_q;
	logic [TW-1:0] out_cnt_q;
	logic          in_done_q;
	logic [TW-1:0] in_cnt_nx;
	logic          real_push;
	logic          real_emit;
	logic          drain_emit;
	logic          m_emit;
	logic          m_last;
	logic [1:0]    owed_q;

	logic res_valid_q;
	assign en = !res_valid_q || result.ready;

	assign acc        = cell_in.valid && cell_in.ready;
	assign is_drain   = (cell_in.req_type == ogdi_pkg::REQ_DRAIN);
	assign in_cnt_nx  = in_cnt_q + TW'(1);
	assign real_push  = acc && !is_drain && !in_done_q;
	assign real_emit  = real_push && ((in_cnt_nx - out_cnt_q) > lag_q);
	assign drain_emit = acc && is_drain && in_done_q && (out_cnt_q < total_q);
	assign m_emit     = real_emit || drain_emit;
	assign m_last     = m_emit && ((out_cnt_q + TW'(1)) >= total_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
			in_done_q <= 1'b0;
		end else if (cfg_rst || m_last) begin
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
			in_done_q <= 1'b0;
		end else begin
			if (real_push) begin
				in_cnt_q <= in_cnt_nx;
				if (in_cnt_nx >= total_q) begin
					in_done_q <= 1'b1;
				end
			end
			if (m_emit) begin
				out_cnt_q <= out_cnt_q + TW'(1);
			end
		end
	end

	// window position counters, push side and centre side
	logic [TW-1:0] dp_q_q;
	logic [CW-1:0] dp_col_q;
	logic [TW-1:0] dp_res_q;
	logic [CW-1:0] dp_ocol_q;
	logic [15:0]   dp_orow_q;
	logic          ph_push;
	logic          ph_prod;
	logic          push;
	logic          prod;
	logic          dp_last;
	logic          src_s0;
	logic [NC-1:0] rowmask_s0;

	assign ph_push = en && (dp_q_q >= total_q) && (dp_res_q < total_q)
		&& ((owed_q != 2'd0) || (dp_q_q < lag_q));
	assign ph_prod = ph_push && (dp_q_q >= lag_q);
	assign push    = real_push || ph_push;
	assign prod    = push && (dp_q_q >= lag_q);
	assign dp_last = prod && (dp_res_q == (total_q - TW'(1)));

	assign cell_in.ready = en && ((owed_q == 2'd0)
		|| ((owed_q == 2'd1) && ph_prod && in_done_q));

	assign src_s0 = real_push && ((cell_in.in_value >= thr_q)
		|| (unk_q && cell_in.in_value[7]));

	always_comb begin
		for (int j = 0; j < NC; j++) begin
			rowmask_s0[j] = (({1'b0, dp_orow_q} + 17'(eff_r_q)) >= 17'(j));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q <= '0;
		end else if (cfg_rst) begin
			owed_q <= '0;
		end else begin
			owed_q <= owed_q + 2'(drain_emit) - 2'(ph_prod);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dp_q_q    <= '0;
			dp_col_q  <= '0;
			dp_res_q  <= '0;
			dp_ocol_q <= '0;
			dp_orow_q <= '0;
		end else if (cfg_rst || dp_last) begin
			dp_q_q    <= '0;
			dp_col_q  <= '0;
			dp_res_q  <= '0;
			dp_ocol_q <= '0;
			dp_orow_q <= '0;
		end else if (push) begin
			dp_q_q   <= dp_q_q + TW'(1);
			dp_col_q <= (WW'(dp_col_q) + WW'(1) == eff_w_q) ? '0 : dp_col_q + CW'(1);
			if (prod) begin
				dp_res_q <= dp_res_q + TW'(1);
				if (WW'(dp_ocol_q) + WW'(1) == eff_w_q) begin
					dp_ocol_q <= '0;
					dp_orow_q <= dp_orow_q + 16'd1;
				end else begin
					dp_ocol_q <= dp_ocol_q + CW'(1);
				end
			end
		end
	end

	// stage 1: column history and delayed value come back from the rams
	logic                 v_s1;
	logic                 prod_s1;
	logic                 last_s1;
	logic                 src_s1;
	logic                 byp_s1;
	logic                 fwd_s1;
	logic [CW-1:0]        col_s1;
	logic [CW-1:0]        ocol_s1;
	logic [NC-1:0]        rowmask_s1;
	ogdi_pkg::occ_value_t val_s1;
	logic [HW-1:0]        hist_rd;
	logic [HW-1:0]        hist_used;
	logic [NC-1:0]        vec_new;
	logic [7:0]           vram_rd;
	logic [TW-1:0]        vrd_addr;
	ogdi_pkg::occ_value_t cval_s1;

	logic [NC-1:0] chain_vec [NC];
	logic [CW-1:0] chain_col [NC];
	logic [NC-1:0] hits;

	assign vrd_addr = dp_q_q - lag_q;

	ogdi_ram #(
		.WIDTH(HW),
		.DEPTH(MAX_WIDTH)
	) u_hist_ram (
		.clk  (clk),
		.we   (v_s1 && en),
		.waddr(col_s1),
		.wdata(vec_new[HW-1:0]),
		.re   (push),
		.raddr(dp_col_q),
		.rdata(hist_rd)
	);

	ogdi_ram #(
		.WIDTH(8),
		.DEPTH(VDEPTH)
	) u_value_ram (
		.clk  (clk),
		.we   (real_push),
		.waddr(dp_q_q[VA-1:0]),
		.wdata(cell_in.in_value),
		.re   (push),
		.raddr(vrd_addr[VA-1:0]),
		.rdata(vram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1    <= prod;
			last_s1    <= dp_last;
			src_s1     <= src_s0;
			byp_s1     <= (lag_q == '0);
			fwd_s1     <= v_s1 && (col_s1 == dp_col_q);
			col_s1     <= dp_col_q;
			ocol_s1    <= dp_ocol_q;
			rowmask_s1 <= rowmask_s0;
			val_s1     <= cell_in.in_value;
		end
	end

	// one-column grid: the previous beat's history is still in flight
	assign hist_used = fwd_s1 ? chain_vec[0][HW-1:0] : hist_rd;
	assign vec_new   = {hist_used, src_s1};
	assign cval_s1   = byp_s1 ? val_s1 : vram_rd;

	for (genvar k = 0; k < NC; k++) begin : g_cell
		logic [NC-1:0] vin;
		logic [CW-1:0] cin;
		if (k == 0) begin : g_head
			assign vin = vec_new;
			assign cin = col_s1;
		end else begin : g_body
			assign vin = chain_vec[k-1];
			assign cin = chain_col[k-1];
		end
		ogdi_cell #(
			.MAX_WIDTH (MAX_WIDTH),
			.MAX_RADIUS(MAX_RADIUS),
			.IDX       (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (v_s1 && en),
			.vec_in    (vin),
			.col_in    (cin),
			.center_col(ocol_s2),
			.radius    (eff_r_q),
			.disk_mask (disk_q[k]),
			.row_mask  (rowmask_s2),
			.vec_out   (chain_vec[k]),
			.col_out   (chain_col[k]),
			.hit       (hits[k])
		);
	end

	// stage 2: window complete in the chain
	logic                 v_s2;
	logic                 last_s2;
	logic [CW-1:0]        ocol_s2;
	logic [NC-1:0]        rowmask_s2;
	ogdi_pkg::occ_value_t val_s2;
	ogdi_pkg::occ_value_t res_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1 && prod_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s2    <= last_s1;
			ocol_s2    <= ocol_s1;
			rowmask_s2 <= rowmask_s1;
			val_s2     <= cval_s1;
		end
	end

	assign res_value = ((|hits) && (thr_q > val_s2)) ? thr_q : val_s2;

	// output register
	ogdi_pkg::occ_value_t res_value_q;
	logic                 res_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_value_q <= res_value;
			res_last_q  <= last_s2;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.out_value = res_value_q;
	assign result.last_cell = res_last_q;

	a_owed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		owed_q <= 2'd1)
		else $error("drain credit overflow");

	a_single_push: assert property (@(posedge clk) disable iff (!arst_n)
		!(real_push && ph_push))
		else $error("grid cell and flush push collide");

	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		dp_res_q < total_q)
		else $error("centre index beyond grid");

endmodule

`default_nettype wire

[rtl/ogdi_ram.sv]
// ogdi_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ogdi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/ogdi_cell.sv]
// ogdi_cell: one column of the disk window, shifted along the chain per pushed cell
// holds the vertical source history of its column and tests it against the disk
`timescale 1ns / 1ps
`default_nettype none

module ogdi_cell #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 8,
	parameter int IDX        = 0
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              shift_en,
	input  wire logic [2*MAX_RADIUS:0]             vec_in,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]      col_in,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]      center_col,
	input  wire logic [$clog2(MAX_RADIUS+1)-1:0]   radius,
	input  wire logic [2*MAX_RADIUS:0]             disk_mask,
	input  wire logic [2*MAX_RADIUS:0]             row_mask,
	output logic      [2*MAX_RADIUS:0]             vec_out,
	output logic      [$clog2(MAX_WIDTH)-1:0]      col_out,
	output logic                                   hit
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_RADIUS+1);
	localparam int MW = (CW > RW) ? CW : RW;
	localparam int DW = ((MW > 7) ? MW : 7) + 2;

	logic [2*MAX_RADIUS:0] vec_q;
	logic [CW-1:0]         col_q;
	logic [DW-1:0]         tgt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_q <= '0;
			col_q <= '0;
		end else if (shift_en) begin
			vec_q <= vec_in;
			col_q <= col_in;
		end
	end

	// same row as the centre only when the column offset matches the stream offset
	assign tgt     = DW'(center_col) + DW'(radius) - DW'(IDX);
	assign hit     = (tgt == DW'(col_q)) && (|(vec_q & disk_mask & row_mask));
	assign vec_out = vec_q;
	assign col_out = col_q;

endmodule

`default_nettype wire
